### rtl/dqrv_pkg.sv
// Shared types and codes for the double-ended queue block.
// Used by dqrv_ctrl, dqrv_dp and the deque_with_remove_by_value top level.
package dqrv_pkg;

    // command codes carried in the input tuser
    localparam logic [3:0] FN_PUSH_FRONT = 4'd0;
    localparam logic [3:0] FN_PUSH_BACK  = 4'd1;
    localparam logic [3:0] FN_POP_FRONT  = 4'd2;
    localparam logic [3:0] FN_POP_BACK   = 4'd3;
    localparam logic [3:0] FN_REMOVE     = 4'd4;
    localparam logic [3:0] FN_CLEAR      = 4'd5;
    localparam logic [3:0] FN_LIST_ALL   = 4'd6;
    localparam logic [3:0] FN_LIST_FIRST = 4'd7;
    localparam logic [3:0] FN_LIST_LAST  = 4'd8;

    // result status codes carried in the output tuser
    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_LISTED = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_NONE   = 3'd4;

    // most elements a single listing returns
    localparam logic [31:0] MAX_RESULTS = 32'd32;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_EXEC      = 11'b000_0000_0010,
        S_SRCH_RD   = 11'b000_0000_0100,
        S_SRCH_CMP  = 11'b000_0000_1000,
        S_SHFT_RD   = 11'b000_0001_0000,
        S_SHFT_WR   = 11'b000_0010_0000,
        S_REM_HIT   = 11'b000_0100_0000,
        S_REM_MISS  = 11'b000_1000_0000,
        S_LIST_NONE = 11'b001_0000_0000,
        S_LIST_RD   = 11'b010_0000_0000,
        S_LIST_OUT  = 11'b100_0000_0000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       load;        // capture the input beat
        logic       exec;        // apply push, pop or clear for the held command
        logic       fill_dec;    // remove finished with a hit
        logic       ptr_clr;     // start a search at the front
        logic       list_init;   // load listing start and count
        logic       step;        // advance the walk pointer, count down
        logic       shift_wr;    // write the read-ahead element one place forward
        logic       rd_next;     // read the element behind the pointer
        logic       out_load;    // load the output register
        logic [2:0] out_status;
        logic       out_listed;  // element field takes the read data
        logic       out_last;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [3:0] func;
        logic       full;
        logic       empty;
        logic       list_zero;   // listing yields no element
        logic       match;       // read data equals the operand
        logic       at_end;      // pointer is on the final element
        logic       shift_end;   // one element left to move
        logic       list_one;    // one element left to list
        logic       out_free;    // output register can take a beat
    } dp_stat_t;

endpackage

### rtl/dqrv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; the queue datapath holds its ring storage here.
module dqrv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/dqrv_ctrl.sv
// Sequencer for the queue: decodes the held command and steps the walks
// for remove and listing. Uses dqrv_pkg for state, command and status types.
module dqrv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dqrv_pkg::dp_stat_t stat,
    output dqrv_pkg::dp_cmd_t  cmd
);

    dqrv_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dqrv_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == dqrv_pkg::S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.out_status = dqrv_pkg::ST_DONE;
        cmd.out_last   = 1'b1;
        unique case (state_reg)
            dqrv_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = dqrv_pkg::S_EXEC;
                end
            end
            dqrv_pkg::S_EXEC:
            begin
                unique case (stat.func) inside
                    dqrv_pkg::FN_REMOVE:
                    begin
                        cmd.ptr_clr = 1'b1;
                        state_next  = stat.empty ? dqrv_pkg::S_REM_MISS
                                                 : dqrv_pkg::S_SRCH_RD;
                    end
                    dqrv_pkg::FN_LIST_ALL, dqrv_pkg::FN_LIST_FIRST,
                    dqrv_pkg::FN_LIST_LAST:
                    begin
                        cmd.list_init = 1'b1;
                        state_next    = stat.list_zero ? dqrv_pkg::S_LIST_NONE
                                                       : dqrv_pkg::S_LIST_RD;
                    end
                    dqrv_pkg::FN_PUSH_FRONT, dqrv_pkg::FN_PUSH_BACK:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.exec       = 1'b1;
                            cmd.out_load   = 1'b1;
                            cmd.out_status = stat.full ? dqrv_pkg::ST_FULL
                                                       : dqrv_pkg::ST_DONE;
                            state_next     = dqrv_pkg::S_IDLE;
                        end
                    end
                    default:
                    begin
                        // pops, clear and unknown codes give a plain done beat
                        if (stat.out_free)
                        begin
                            cmd.exec     = 1'b1;
                            cmd.out_load = 1'b1;
                            state_next   = dqrv_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            dqrv_pkg::S_SRCH_RD:
            begin
                state_next = dqrv_pkg::S_SRCH_CMP;
            end
            dqrv_pkg::S_SRCH_CMP:
            begin
                if (stat.match)
                begin
                    state_next = stat.at_end ? dqrv_pkg::S_REM_HIT
                                             : dqrv_pkg::S_SHFT_RD;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = stat.at_end ? dqrv_pkg::S_REM_MISS
                                             : dqrv_pkg::S_SRCH_RD;
                end
            end
            dqrv_pkg::S_SHFT_RD:
            begin
                cmd.rd_next = 1'b1;
                state_next  = dqrv_pkg::S_SHFT_WR;
            end
            dqrv_pkg::S_SHFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.step     = 1'b1;
                state_next   = stat.shift_end ? dqrv_pkg::S_REM_HIT
                                              : dqrv_pkg::S_SHFT_RD;
            end
            dqrv_pkg::S_REM_HIT:
            begin
                if (stat.out_free)
                begin
                    cmd.fill_dec = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = dqrv_pkg::S_IDLE;
                end
            end
            dqrv_pkg::S_REM_MISS:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = dqrv_pkg::ST_NONE;
                    state_next     = dqrv_pkg::S_IDLE;
                end
            end
            dqrv_pkg::S_LIST_NONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = dqrv_pkg::ST_EMPTY;
                    state_next     = dqrv_pkg::S_IDLE;
                end
            end
            dqrv_pkg::S_LIST_RD:
            begin
                state_next = dqrv_pkg::S_LIST_OUT;
            end
            dqrv_pkg::S_LIST_OUT:
            begin
                // read address holds on the pointer, so the data waits out a stall
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = dqrv_pkg::ST_LISTED;
                    cmd.out_listed = 1'b1;
                    cmd.out_last   = stat.list_one;
                    cmd.step       = 1'b1;
                    state_next     = stat.list_one ? dqrv_pkg::S_IDLE
                                                   : dqrv_pkg::S_LIST_RD;
                end
            end
            default:
            begin
                state_next = dqrv_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/dqrv_dp.sv
// Datapath of the queue: head and fill registers, walk pointer and count,
// ring storage in dqrv_ram, and the output register. Uses dqrv_pkg.
module dqrv_dp #(
    parameter int CAPACITY = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [3:0]         in_func,
    input  logic [31:0]        in_operand,
    input  dqrv_pkg::dp_cmd_t  cmd,
    output dqrv_pkg::dp_stat_t stat,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [2:0]         out_status,
    output logic [31:0]        out_element,
    output logic [5:0]         out_occupancy,
    output logic               out_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [3:0]    func_reg;
    logic [31:0]   operand_reg;

    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic [31:0]   out_element_reg;
    logic [5:0]    out_occ_reg;
    logic          out_last_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    logic          full, empty, is_push;
    logic [AW-1:0] head_dec;
    logic [SW-1:0] ptr_ext, ptr_inc1, ptr_inc2, fill_ext;
    logic [31:0]   lim32, n32;
    logic [CW-1:0] list_n, list_first;

    // head plus offset, wrapped once into the ring
    function automatic logic [AW-1:0] ring(input logic [AW-1:0] head, input logic [SW-1:0] ofs);
        logic [SW-1:0] sum;
        sum = SW'(head) + ofs;
        if (sum >= SW'(CAPACITY))
        begin
            sum = sum - SW'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign full     = (fill_reg == CW'(CAPACITY));
    assign empty    = (fill_reg == '0);
    assign head_dec = (head_reg == '0) ? AW'(CAPACITY - 1) : head_reg - AW'(1);
    assign ptr_ext  = SW'(ptr_reg);
    assign ptr_inc1 = ptr_ext + SW'(1);
    assign ptr_inc2 = ptr_ext + SW'(2);
    assign fill_ext = SW'(fill_reg);
    assign is_push  = (func_reg == dqrv_pkg::FN_PUSH_FRONT) ||
                      (func_reg == dqrv_pkg::FN_PUSH_BACK);

    // listing length: clamp to occupancy and to the result limit
    always_comb
    begin
        lim32 = (32'(fill_reg) > dqrv_pkg::MAX_RESULTS) ? dqrv_pkg::MAX_RESULTS
                                                        : 32'(fill_reg);
        if (func_reg == dqrv_pkg::FN_LIST_ALL)
        begin
            n32 = lim32;
        end
        else if (operand_reg[31] || operand_reg == '0)
        begin
            n32 = '0;
        end
        else
        begin
            n32 = (operand_reg < lim32) ? operand_reg : lim32;
        end
        list_n     = n32[CW-1:0];
        list_first = (func_reg == dqrv_pkg::FN_LIST_LAST) ? fill_reg - list_n : '0;
    end

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (cmd.exec)
        begin
            case (func_reg)
                dqrv_pkg::FN_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        head_next = head_dec;
                        fill_next = fill_reg + CW'(1);
                    end
                end
                dqrv_pkg::FN_PUSH_BACK:
                begin
                    if (!full)
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                end
                dqrv_pkg::FN_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        head_next = ring(head_reg, SW'(1));
                        fill_next = fill_reg - CW'(1);
                    end
                end
                dqrv_pkg::FN_POP_BACK:
                begin
                    if (!empty)
                    begin
                        fill_next = fill_reg - CW'(1);
                    end
                end
                dqrv_pkg::FN_CLEAR:
                begin
                    fill_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.fill_dec)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        cnt_next = cnt_reg;
        if (cmd.ptr_clr)
        begin
            ptr_next = '0;
        end
        else if (cmd.list_init)
        begin
            ptr_next = list_first;
            cnt_next = list_n;
        end
        else if (cmd.step)
        begin
            ptr_next = ptr_inc1[CW-1:0];
            cnt_next = cnt_reg - CW'(1);
        end
    end

    // ring write: pushes take the operand, the remove shift takes the read-ahead
    always_comb
    begin
        ram_we    = (cmd.exec && is_push && !full) || cmd.shift_wr;
        ram_wdata = cmd.shift_wr ? ram_rdata : operand_reg;
        if (cmd.shift_wr)
        begin
            ram_waddr = ring(head_reg, ptr_ext);
        end
        else if (func_reg == dqrv_pkg::FN_PUSH_FRONT)
        begin
            ram_waddr = head_dec;
        end
        else
        begin
            ram_waddr = ring(head_reg, fill_ext);
        end
        ram_raddr = ring(head_reg, cmd.rd_next ? ptr_inc1 : ptr_ext);
    end

    dqrv_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        cnt_reg <= cnt_next;
        if (cmd.load)
        begin
            func_reg    <= in_func;
            operand_reg <= in_operand;
        end
        if (cmd.out_load)
        begin
            out_status_reg  <= cmd.out_status;
            out_element_reg <= cmd.out_listed ? ram_rdata : '0;
            out_occ_reg     <= 6'(fill_next);
            out_last_reg    <= cmd.out_last;
        end
    end

    always_comb
    begin
        stat.func      = func_reg;
        stat.full      = full;
        stat.empty     = empty;
        stat.list_zero = (list_n == '0);
        stat.match     = (ram_rdata == operand_reg);
        stat.at_end    = (ptr_inc1 >= fill_ext);
        stat.shift_end = (ptr_inc2 >= fill_ext);
        stat.list_one  = (cnt_reg == CW'(1));
        stat.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_element   = out_element_reg;
    assign out_occupancy = out_occ_reg;
    assign out_last      = out_last_reg;

endmodule

### rtl/deque_with_remove_by_value.sv
// Top level of the bounded double-ended queue with remove by value.
// Joins dqrv_ctrl and dqrv_dp; types and codes come from dqrv_pkg.
//
//   channel  dir  handshake          payload
//   s_axis   in   s_tvalid/s_tready  s_tuser = func, s_tdata = operand
//   m_axis   out  m_tvalid/m_tready  m_tuser = status, m_tdata = element,
//                                    occupancy, m_tlast = last
//
// One command at a time. Push, pop and clear apply and load their result in exec.
// Remove compares each element from the front; a hit closes the gap by moving each
// later one forward, read then written: the RAM has a single registered read port.
// Listing reads, then loads, each element. Input is taken again the cycle after the
// final result is loaded; m_tready low stalls the sequencer on its next beat.
// Reset clears head, fill, output valid and state; ring storage is not cleared.
module deque_with_remove_by_value #(
    parameter int CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand
    input  logic [7:0]  s_tuser,   // [3:0] func, [7:4] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] element, [37:32] occupancy, [39:38] zero
    output logic [7:0]  m_tuser,   // [2:0] status, [7:3] zero
    output logic        m_tlast
);

    dqrv_pkg::dp_cmd_t  cmd;
    dqrv_pkg::dp_stat_t stat;
    logic [2:0]         out_status;
    logic [31:0]        out_element;
    logic [5:0]         out_occupancy;

    dqrv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dqrv_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_func       (s_tuser[3:0]),
        .in_operand    (s_tdata),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_status    (out_status),
        .out_element   (out_element),
        .out_occupancy (out_occupancy),
        .out_last      (m_tlast)
    );

    assign m_tdata = {2'b00, out_occupancy, out_element};
    assign m_tuser = {5'b00000, out_status};

`ifndef SYNTH
    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while stalled");

    // only a listed element carries a value
    a_element_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2:0] != dqrv_pkg::ST_LISTED) |-> (m_tdata[31:0] == '0))
        else $error("nonzero element on a status beat");

    // a single-result command always ends its run
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2:0] != dqrv_pkg::ST_LISTED) |-> m_tlast)
        else $error("status beat without last");

    // a new command is taken only after its predecessor's result is loaded
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second command taken while one is running");
`endif

endmodule
